@@ hw/rtl/qvr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_pkg
// Widths, shift amounts and shared types of the quaternion vector rotate unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

  localparam int QW        = 16;  // quaternion component, Q1.14
  localparam int VW        = 32;  // vector component
  localparam int SQ_W      = 33;  // sum of squares
  localparam int SQ_SHIFT  = 28;  // radicand is sum << 28
  localparam int ROOT_W    = 31;  // floor(sqrt(sum << 28))
  localparam int NUM_SHIFT = 38;  // numerator is |q| << 38
  localparam int NUM_W     = QW + NUM_SHIFT;
  localparam int QUO_W     = 25;  // quotient magnitude bits
  localparam int N_W       = QUO_W + 1;
  localparam int UV_SHIFT  = 20;
  localparam int OUT_SHIFT = 28;
  localparam int PNV_W     = N_W + VW;        // n * v
  localparam int UV_W      = 38;
  localparam int PNU_W     = N_W + UV_W;      // n * uv
  localparam int T_W       = PNU_W + 2;
  localparam int RES_W     = 40;

  typedef struct packed {
    logic                   zero;
    logic [3:0][QW-1:0]     q;
    logic [2:0][VW-1:0]     v;
  } qvr_item_t;

  typedef struct packed {
    logic                   zero;
    logic [2:0][VW-1:0]     v;
  } qvr_vec_t;

endpackage

@@ hw/rtl/qvr_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_isqrt
// Pipelined integer square root of (sum << 28), one result bit per stage.
// ----------------------------------------------------------------------------
module qvr_isqrt
  import qvr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SQ_W-1:0]   in_s,
  input  qvr_item_t         in_item,
  output logic              out_vld,
  output logic [ROOT_W-1:0] out_root,
  output qvr_item_t         out_item
);

  localparam int STEPS = ROOT_W;
  localparam int RAD_W = 2 * ROOT_W;

  logic              vld_r  [0:STEPS];
  logic [SQ_W-1:0]   s_r    [0:STEPS];
  logic [ROOT_W-1:0] root_r [0:STEPS];
  logic [SQ_W-1:0]   rem_r  [0:STEPS];
  qvr_item_t         item_r [0:STEPS];

  assign vld_r[0]  = in_vld;
  assign s_r[0]    = in_s;
  assign root_r[0] = '0;
  assign rem_r[0]  = '0;
  assign item_r[0] = in_item;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [RAD_W-1:0]  rad;
    logic [SQ_W+1:0]   trem;
    logic [SQ_W+1:0]   trial;
    logic              fit;

    assign rad   = {{(RAD_W-SQ_W-SQ_SHIFT){1'b0}}, s_r[k], {SQ_SHIFT{1'b0}}};
    assign trem  = {rem_r[k], rad[RAD_W-1-2*k -: 2]};
    assign trial = {{(SQ_W-ROOT_W){1'b0}}, root_r[k], 2'b01};
    assign fit   = (trem >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        s_r[k+1]    <= s_r[k];
        item_r[k+1] <= item_r[k];
        root_r[k+1] <= {root_r[k][ROOT_W-2:0], fit};
        rem_r[k+1]  <= fit ? SQ_W'(trem - trial) : trem[SQ_W-1:0];
      end
    end
  end

  assign out_vld  = vld_r[STEPS];
  assign out_root = root_r[STEPS];
  assign out_item = item_r[STEPS];

endmodule

@@ hw/rtl/qvr_divide.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qvr_divide
// Four-lane pipelined restoring divider: n = round(q * 2^38 / r), half away
// from zero, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_divide
  import qvr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [ROOT_W-1:0]     in_root,
  input  logic [3:0][QW-1:0]    in_q,
  input  qvr_vec_t              in_vec,
  output logic                  out_vld,
  output logic [3:0][N_W-1:0]   out_n,
  output qvr_vec_t              out_vec
);

  localparam int REM_W = ROOT_W;

  logic                   vld_r  [0:QUO_W];
  logic [ROOT_W-1:0]      root_r [0:QUO_W];
  logic [3:0]             neg_r  [0:QUO_W];
  logic [3:0][REM_W-1:0]  rem_r  [0:QUO_W];
  logic [3:0][QUO_W-1:0]  sh_r   [0:QUO_W];
  qvr_vec_t               vec_r  [0:QUO_W];

  logic [3:0][NUM_W-1:0]  num;
  logic [3:0][QW-1:0]     mag;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = in_q[i][QW-1] ? QW'(-in_q[i]) : in_q[i];
      num[i] = {mag[i], {NUM_SHIFT{1'b0}}} + NUM_W'(in_root >> 1);
    end
  end

  // numerator setup
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      root_r[0] <= in_root;
      vec_r[0]  <= in_vec;
      for (int i = 0; i < 4; i++) begin
        neg_r[0][i] <= in_q[i][QW-1];
        rem_r[0][i] <= REM_W'(num[i][NUM_W-1:QUO_W]);
        sh_r[0][i]  <= num[i][QUO_W-1:0];
      end
    end
  end

  for (genvar k = 0; k < QUO_W; k++) begin : g_step
    logic [3:0][REM_W:0] trem;
    logic [3:0]          fit;

    always_comb begin
      for (int i = 0; i < 4; i++) begin
        trem[i] = {rem_r[k][i], sh_r[k][i][QUO_W-1]};
        fit[i]  = (trem[i] >= {1'b0, root_r[k]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k+1] <= root_r[k];
        neg_r[k+1]  <= neg_r[k];
        vec_r[k+1]  <= vec_r[k];
        for (int i = 0; i < 4; i++) begin
          rem_r[k+1][i] <= fit[i] ? REM_W'(trem[i] - {1'b0, root_r[k]})
                                  : trem[i][REM_W-1:0];
          sh_r[k+1][i]  <= {sh_r[k][i][QUO_W-2:0], fit[i]};
        end
      end
    end
  end

  // sign restore
  logic                 fin_vld_r;
  logic [3:0][N_W-1:0]  fin_n_r;
  qvr_vec_t             fin_vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_vld_r <= 1'b0;
    end else if (en) begin
      fin_vld_r <= vld_r[QUO_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_vec_r <= vec_r[QUO_W];
      for (int i = 0; i < 4; i++) begin
        fin_n_r[i] <= neg_r[QUO_W][i] ? N_W'(-{1'b0, sh_r[QUO_W][i]})
                                      : {1'b0, sh_r[QUO_W][i]};
      end
    end
  end

  assign out_vld = fin_vld_r;
  assign out_n   = fin_n_r;
  assign out_vec = fin_vec_r;

endmodule

@@ hw/rtl/quaternion_vector_rotate_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Normalizes a Q1.14 quaternion and rotates a Q15.16 vector by it:
// v + 2w(qv x v) + 2 qv x (qv x v), rounded and saturated.
//
//   channel  ports                                   handshake
//   input    in_quat_w/x/y/z, in_vec_x/y/z           in_valid / in_stall
//   output   out_rot_x/y/z, out_zero_quat            out_valid / out_stall
//
// One transfer per cycle sustained while in_stall is low; 65 register
// stages: 2 square/sum stages, 31 square-root stages, 27 divider stages,
// 4 rotate stages and the output register.
// Synchronous active-low reset clears valid bits only.
// A two-entry output register/skid parts the sides; in_stall is registered
// and rises only when the skid entry is occupied, freezing the pipeline.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit
  import qvr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [QW-1:0] in_quat_w,
  input  logic signed [QW-1:0] in_quat_x,
  input  logic signed [QW-1:0] in_quat_y,
  input  logic signed [QW-1:0] in_quat_z,
  input  logic signed [VW-1:0] in_vec_x,
  input  logic signed [VW-1:0] in_vec_y,
  input  logic signed [VW-1:0] in_vec_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [VW-1:0] out_rot_x,
  output logic signed [VW-1:0] out_rot_y,
  output logic signed [VW-1:0] out_rot_z,
  output logic                 out_zero_quat
);

  logic skid_full_r;
  logic out_valid_r;
  logic pipe_en;

  assign pipe_en  = !skid_full_r;
  assign in_stall = skid_full_r;

  // ---------------- squares
  logic              sq_vld_r;
  logic [QW*2-2:0]   sq_r [4];
  qvr_item_t         sq_item_r;
  qvr_item_t         in_item;

  always_comb begin
    in_item.zero = (in_quat_w == '0) && (in_quat_x == '0) &&
                   (in_quat_y == '0) && (in_quat_z == '0);
    in_item.q    = {in_quat_z, in_quat_y, in_quat_x, in_quat_w};
    in_item.v    = {in_vec_z, in_vec_y, in_vec_x};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
    end else if (pipe_en) begin
      sq_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_item_r <= in_item;
      sq_r[0]   <= (QW*2-1)'(in_quat_w * in_quat_w);
      sq_r[1]   <= (QW*2-1)'(in_quat_x * in_quat_x);
      sq_r[2]   <= (QW*2-1)'(in_quat_y * in_quat_y);
      sq_r[3]   <= (QW*2-1)'(in_quat_z * in_quat_z);
    end
  end

  // ---------------- sum
  logic            sum_vld_r;
  logic [SQ_W-1:0] sum_r;
  qvr_item_t       sum_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (pipe_en) begin
      sum_vld_r <= sq_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sum_item_r <= sq_item_r;
      sum_r      <= SQ_W'(sq_r[0]) + SQ_W'(sq_r[1]) + SQ_W'(sq_r[2]) + SQ_W'(sq_r[3]);
    end
  end

  // ---------------- norm and normalize
  logic              rt_vld;
  logic [ROOT_W-1:0] rt_root;
  qvr_item_t         rt_item;

  qvr_isqrt u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (pipe_en),
    .in_vld   (sum_vld_r),
    .in_s     (sum_r),
    .in_item  (sum_item_r),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_item (rt_item)
  );

  qvr_vec_t             rt_vec;
  logic                 dv_vld;
  logic [3:0][N_W-1:0]  dv_n;
  qvr_vec_t             dv_vec;

  assign rt_vec.zero = rt_item.zero;
  assign rt_vec.v    = rt_item.v;

  qvr_divide u_divide (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_vld  (rt_vld),
    .in_root (rt_root),
    .in_q    (rt_item.q),
    .in_vec  (rt_vec),
    .out_vld (dv_vld),
    .out_n   (dv_n),
    .out_vec (dv_vec)
  );

  logic signed [N_W-1:0] n_s [4];
  logic signed [VW-1:0]  v_s [3];

  always_comb begin
    for (int i = 0; i < 4; i++) n_s[i] = $signed(dv_n[i]);
    for (int i = 0; i < 3; i++) v_s[i] = $signed(dv_vec.v[i]);
  end

  // ---------------- P1: qv x v products
  logic                    p1_vld_r;
  logic signed [PNV_W-1:0] p1_a_r [3];
  logic signed [PNV_W-1:0] p1_b_r [3];
  logic signed [N_W-1:0]   p1_n_r [4];
  qvr_vec_t                p1_vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else if (pipe_en) begin
      p1_vld_r <= dv_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p1_vec_r  <= dv_vec;
      p1_n_r    <= n_s;
      p1_a_r[0] <= n_s[2] * v_s[2];
      p1_b_r[0] <= n_s[3] * v_s[1];
      p1_a_r[1] <= n_s[3] * v_s[0];
      p1_b_r[1] <= n_s[1] * v_s[2];
      p1_a_r[2] <= n_s[1] * v_s[1];
      p1_b_r[2] <= n_s[2] * v_s[0];
    end
  end

  // ---------------- P2: uv, rounded to 4 guard bits
  logic                   p2_vld_r;
  logic signed [UV_W-1:0] p2_uv_r [3];
  logic signed [N_W-1:0]  p2_n_r  [4];
  qvr_vec_t               p2_vec_r;
  logic signed [PNV_W:0]  uv_sum  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      uv_sum[i] = p1_a_r[i] - p1_b_r[i] + ((PNV_W+1)'(1) <<< (UV_SHIFT-1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_vld_r <= 1'b0;
    end else if (pipe_en) begin
      p2_vld_r <= p1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p2_vec_r <= p1_vec_r;
      p2_n_r   <= p1_n_r;
      for (int i = 0; i < 3; i++) begin
        p2_uv_r[i] <= $signed(uv_sum[i][UV_SHIFT+UV_W-1:UV_SHIFT]);
      end
    end
  end

  // ---------------- P3: w*uv and qv x uv products
  logic                    p3_vld_r;
  logic signed [PNU_W-1:0] p3_w_r [3];
  logic signed [PNU_W-1:0] p3_c_r [3];
  logic signed [PNU_W-1:0] p3_d_r [3];
  qvr_vec_t                p3_vec_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_vld_r <= 1'b0;
    end else if (pipe_en) begin
      p3_vld_r <= p2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p3_vec_r  <= p2_vec_r;
      p3_c_r[0] <= p2_n_r[2] * p2_uv_r[2];
      p3_d_r[0] <= p2_n_r[3] * p2_uv_r[1];
      p3_c_r[1] <= p2_n_r[3] * p2_uv_r[0];
      p3_d_r[1] <= p2_n_r[1] * p2_uv_r[2];
      p3_c_r[2] <= p2_n_r[1] * p2_uv_r[1];
      p3_d_r[2] <= p2_n_r[2] * p2_uv_r[0];
      for (int i = 0; i < 3; i++) p3_w_r[i] <= p2_n_r[0] * p2_uv_r[i];
    end
  end

  // ---------------- P4: accumulate, round, add v
  logic                    p4_vld_r;
  logic signed [RES_W-1:0] p4_res_r [3];
  qvr_vec_t                p4_vec_r;
  logic signed [T_W-1:0]   t_sum    [3];
  logic signed [RES_W-1:0] res_sum  [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t_sum[i]   = (T_W'(p3_w_r[i]) <<< 1) + ((T_W'(p3_c_r[i]) - T_W'(p3_d_r[i])) <<< 1)
                   + (T_W'(1) <<< (OUT_SHIFT-1));
      res_sum[i] = RES_W'($signed(p3_vec_r.v[i]))
                   + RES_W'($signed(t_sum[i][T_W-1:OUT_SHIFT]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p4_vld_r <= 1'b0;
    end else if (pipe_en) begin
      p4_vld_r <= p3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      p4_vec_r <= p3_vec_r;
      p4_res_r <= res_sum;
    end
  end

  // ---------------- saturate / zero pass-through
  logic [2:0][VW-1:0] fin_rot;
  localparam logic signed [RES_W-1:0] SAT_HI = RES_W'({1'b0, {(VW-1){1'b1}}});
  localparam logic signed [RES_W-1:0] SAT_LO = -(RES_W'(1) <<< (VW-1));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (p4_vec_r.zero) begin
        fin_rot[i] = p4_vec_r.v[i];
      end else if (p4_res_r[i] > SAT_HI) begin
        fin_rot[i] = {1'b0, {(VW-1){1'b1}}};
      end else if (p4_res_r[i] < SAT_LO) begin
        fin_rot[i] = {1'b1, {(VW-1){1'b0}}};
      end else begin
        fin_rot[i] = p4_res_r[i][VW-1:0];
      end
    end
  end

  // ---------------- output register and skid
  logic [2:0][VW-1:0] out_rot_r;
  logic               out_zero_r;
  logic [2:0][VW-1:0] skid_rot_r;
  logic               skid_zero_r;
  logic               take_p;

  assign take_p = pipe_en && p4_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else if (out_valid_r && out_stall) begin
      if (take_p) skid_full_r <= 1'b1;
    end else if (skid_full_r) begin
      out_valid_r <= 1'b1;
      skid_full_r <= 1'b0;
    end else begin
      out_valid_r <= take_p;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid_r && out_stall) begin
      if (take_p) begin
        skid_rot_r  <= fin_rot;
        skid_zero_r <= p4_vec_r.zero;
      end
    end else if (skid_full_r) begin
      out_rot_r  <= skid_rot_r;
      out_zero_r <= skid_zero_r;
    end else if (take_p) begin
      out_rot_r  <= fin_rot;
      out_zero_r <= p4_vec_r.zero;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_rot_x     = $signed(out_rot_r[0]);
  assign out_rot_y     = $signed(out_rot_r[1]);
  assign out_rot_z     = $signed(out_rot_r[2]);
  assign out_zero_quat = out_zero_r;

`ifndef SYNTH
  a_skid_needs_out : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r |-> out_valid_r)
    else $error("skid entry held without output entry");

  a_skid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    skid_full_r && out_stall |=> skid_full_r)
    else $error("skid entry dropped while output stalled");

  a_freeze : assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> $stable(p4_vld_r) && $stable(p2_vld_r))
    else $error("pipeline moved while frozen");
`endif

endmodule
